FILE: rtl/arpc_pkg.sv
`timescale 1ns / 1ps
// arpc_pkg: shared types and codes for the arp cache and responder
// no dependencies; used by arpc_cell and arp_cache_and_responder
package arpc_pkg;

  localparam int IpW   = 32;
  localparam int MacW  = 48;
  localparam int OpW   = 16;
  localparam int HostW = 8;
  localparam int ActW  = 2;
  localparam int KindW = 2;
  localparam int ResOpW = 2;

  // stream payload widths, padded to whole bytes
  localparam int InDataW  = 136;
  localparam int OutDataW = 168;

  // input actions
  localparam logic [ActW-1:0] ACT_RX_ARP = 2'd0;
  localparam logic [ActW-1:0] ACT_LOOKUP = 2'd1;
  localparam logic [ActW-1:0] ACT_PROBE  = 2'd2;
  localparam logic [ActW-1:0] ACT_INSERT = 2'd3;

  // result kinds
  localparam logic [KindW-1:0] KIND_REPLY   = 2'd0;
  localparam logic [KindW-1:0] KIND_REQUEST = 2'd1;
  localparam logic [KindW-1:0] KIND_FORWARD = 2'd2;
  localparam logic [KindW-1:0] KIND_STATUS  = 2'd3;

  // arp opcodes
  localparam logic [OpW-1:0]    ARP_OP_REQUEST = 16'd1;
  localparam logic [OpW-1:0]    ARP_OP_REPLY   = 16'd2;
  localparam logic [ResOpW-1:0] RES_OP_NONE    = 2'd0;
  localparam logic [ResOpW-1:0] RES_OP_REQUEST = 2'd1;
  localparam logic [ResOpW-1:0] RES_OP_REPLY   = 2'd2;

  // register indexes
  localparam logic REG_LOCAL_IP  = 1'b0;
  localparam logic REG_LOCAL_MAC = 1'b1;

  localparam logic [MacW-1:0] BCAST_MAC   = 48'hFFFF_FFFF_FFFF;
  localparam logic [IpW-1:0]  SUBNET_MASK = 32'hFFFF_FF00;

  typedef struct packed {
    logic [IpW-1:0]  ip;
    logic [MacW-1:0] mac;
  } entry_t;

  typedef struct packed {
    logic           shift;
    logic [IpW-1:0] key;
  } cell_ctrl_t;

  typedef struct packed {
    logic [ActW-1:0]  action;
    logic [OpW-1:0]   arp_op;
    logic [IpW-1:0]   sender_ip;
    logic [MacW-1:0]  sender_mac;
    logic [IpW-1:0]   target_ip;
    logic [HostW-1:0] host_number;
  } item_t;

endpackage

FILE: rtl/arpc_cell.sv
`timescale 1ns / 1ps
// arpc_cell: one cache entry of the chain, shifts in from its neighbor on insert
// and registers a compare against the broadcast key; depends on arpc_pkg
module arpc_cell
  import arpc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic             valid_i,
  input  entry_t           entry_i,
  output entry_t           entry_o,
  output logic             hit_o,
  output logic [MacW-1:0]  mac_o
);

  entry_t entry_q;
  logic   hit_q;
  logic   hit_d;

  assign hit_d = valid_i && (entry_q.ip == ctrl_i.key);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      entry_q <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign entry_o = entry_q;
  assign hit_o   = hit_q;
  assign mac_o   = hit_q ? entry_q.mac : '0;

endmodule

FILE: rtl/arp_cache_and_responder.sv
`timescale 1ns / 1ps
// arp_cache_and_responder: ip-to-mac cache built as a row of arpc_cell entries,
// arp reply/request generation, apb register block; depends on arpc_pkg, arpc_cell
//
//  channel   dir   handshake                    payload
//  s_axis    in    tvalid / tready              tuser action, tdata packet fields
//  m_axis    out   tvalid / tready              tuser result kind, tdata header fields
//  apb       in    psel & penable & pwrite      local_ip at 0x0, local_mac at 0x8
//
//  an item passes the states accept, compare in every cell, and reduce the cell hits
//  and build the result; the cell compare register and hit or-tree split these steps
//  the result stage of an item with a result waits while the output register still holds an untaken transfer
//  an insert shifts every cell one place along the chain in the result stage
//  reset clears the entry count, control state and registers; entries are not cleared
module arp_cache_and_responder
  import arpc_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // fields from bit 0: arp_op, sender_ip, sender_mac, target_ip, host_number
  input  logic [InDataW-1:0]    s_axis_tdata,
  // fields from bit 0: action
  input  logic [ActW-1:0]       s_axis_tuser,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // fields from bit 0: arp_op_res, eth_dst_mac, arp_target_mac, arp_sender_ip,
  // arp_target_ip, was_new, table_full, zero fill
  output logic [OutDataW-1:0]   m_axis_tdata,
  // fields from bit 0: result_kind
  output logic [KindW-1:0]      m_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [63:0]           pwdata,
  output logic [63:0]           prdata,
  output logic                  pready
);

  localparam int CntW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_RES  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IpW-1:0]  local_ip_q;
  logic [MacW-1:0] local_mac_q;
  item_t           item_q;
  logic [IpW-1:0]  key_q, key_d;
  item_t           in_item;

  logic                 out_valid_q, out_valid_d;
  logic [OutDataW-1:0]  out_data_q, out_data_d;
  logic [KindW-1:0]     out_kind_q, out_kind_d;

  cell_ctrl_t          cell_ctrl;
  entry_t              new_entry;
  entry_t              cell_entry [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] hit_vec;
  logic [MacW-1:0]     mac_vec [TABLE_DEPTH];

  logic            found;
  logic [MacW-1:0] hit_mac;
  logic            table_full;
  logic            for_us;
  logic            has_result;
  logic            learn;
  logic            res_fire;
  logic            do_insert;
  logic            cfg_write;

  logic [ResOpW-1:0] r_op;
  logic [MacW-1:0]   r_edst;
  logic [MacW-1:0]   r_tmac;
  logic [IpW-1:0]    r_sip;
  logic [IpW-1:0]    r_tip;
  logic              r_new;
  logic              r_full;

  // input unpacking
  assign in_item.action      = s_axis_tuser;
  assign in_item.arp_op      = s_axis_tdata[15:0];
  assign in_item.sender_ip   = s_axis_tdata[47:16];
  assign in_item.sender_mac  = s_axis_tdata[95:48];
  assign in_item.target_ip   = s_axis_tdata[127:96];
  assign in_item.host_number = s_axis_tdata[135:128];

  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    case (in_item.action)
      ACT_LOOKUP: key_d = in_item.target_ip;
      ACT_PROBE:  key_d = (local_ip_q & SUBNET_MASK) | {24'b0, in_item.host_number};
      default:    key_d = in_item.sender_ip;
    endcase
  end

  // cell chain
  assign new_entry.ip  = item_q.sender_ip;
  assign new_entry.mac = item_q.sender_mac;
  assign cell_ctrl.shift = do_insert;
  assign cell_ctrl.key   = key_q;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t prev_entry;
    if (i == 0) begin : g_head
      assign prev_entry = new_entry;
    end else begin : g_body
      assign prev_entry = cell_entry[i-1];
    end
    arpc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .valid_i (count_q > CntW'(i)),
      .entry_i (prev_entry),
      .entry_o (cell_entry[i]),
      .hit_o   (hit_vec[i]),
      .mac_o   (mac_vec[i])
    );
  end

  always_comb begin
    hit_mac = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_mac = hit_mac | mac_vec[i];
    end
  end

  assign found      = |hit_vec;
  assign table_full = (count_q == CntW'(TABLE_DEPTH));
  assign for_us     = (item_q.target_ip == local_ip_q);

  assign has_result = (item_q.action != ACT_RX_ARP) ||
                      (for_us && item_q.arp_op == ARP_OP_REQUEST);
  assign learn      = (item_q.action == ACT_INSERT) ||
                      (item_q.action == ACT_RX_ARP && for_us &&
                       item_q.arp_op == ARP_OP_REPLY);

  assign res_fire  = (state_q == ST_RES) &&
                     (!has_result || !out_valid_q || m_axis_tready);
  assign do_insert = res_fire && learn && !found && !table_full;

  // result fields
  always_comb begin
    r_op   = RES_OP_NONE;
    r_edst = '0;
    r_tmac = '0;
    r_sip  = '0;
    r_tip  = '0;
    r_new  = 1'b0;
    r_full = 1'b0;
    out_kind_d = KIND_STATUS;
    case (item_q.action)
      ACT_RX_ARP: begin
        out_kind_d = KIND_REPLY;
        r_op   = RES_OP_REPLY;
        r_edst = item_q.sender_mac;
        r_tmac = item_q.sender_mac;
        r_sip  = local_ip_q;
        r_tip  = item_q.sender_ip;
      end
      ACT_LOOKUP: begin
        r_tip = key_q;
        if (found) begin
          out_kind_d = KIND_FORWARD;
          r_edst = hit_mac;
        end else begin
          out_kind_d = KIND_REQUEST;
          r_op   = RES_OP_REQUEST;
          r_edst = BCAST_MAC;
          r_sip  = local_ip_q;
        end
      end
      ACT_PROBE: begin
        out_kind_d = KIND_REQUEST;
        r_op  = RES_OP_REQUEST;
        r_sip = local_ip_q;
        r_tip = key_q;
        if (found) begin
          r_edst = hit_mac;
          r_tmac = hit_mac;
        end else begin
          r_edst = BCAST_MAC;
        end
      end
      default: begin
        out_kind_d = KIND_STATUS;
        r_new  = !found;
        r_full = !found && table_full;
      end
    endcase
  end

  assign out_data_d = {4'b0, r_full, r_new, r_tip, r_sip, r_tmac, r_edst, r_op};

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        state_d = ST_RES;
      end
      ST_RES: begin
        if (res_fire) begin
          state_d = ST_IDLE;
          if (has_result) begin
            out_valid_d = 1'b1;
          end
          if (do_insert) begin
            count_d = count_q + CntW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q <= in_item;
      key_q  <= key_d;
    end
    if (res_fire && has_result) begin
      out_data_q <= out_data_d;
      out_kind_q <= out_kind_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;

  // register block
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_ip_q  <= '0;
      local_mac_q <= '0;
    end else if (cfg_write) begin
      case (paddr[3])
        REG_LOCAL_IP:  local_ip_q  <= pwdata[IpW-1:0];
        REG_LOCAL_MAC: local_mac_q <= pwdata[MacW-1:0];
        default: begin
          local_ip_q <= local_ip_q;
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      REG_LOCAL_IP:  prdata = {32'b0, local_ip_q};
      REG_LOCAL_MAC: prdata = {16'b0, local_mac_q};
      default:       prdata = '0;
    endcase
  end

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_unique_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec))
    else $error("more than one cell matched the key");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_insert |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not advance the entry count");

  a_insert_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_ctrl.shift |-> (state_q == ST_RES && !found))
    else $error("cell shift outside the result stage or on a hit");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RES))
    else $error("output loaded outside the result stage");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// testbench: directed and random arp actions into arp_cache_and_responder, each result
// checked field by field against a cache model kept here; depends on arpc_pkg and the rtl
module testbench;
  import arpc_pkg::*;

  localparam int TableDepth  = 64;
  localparam int PoolSize    = 128;
  localparam int PhaseCount  = 8;
  localparam int PhaseItems  = 250;
  localparam int SettleCycles = 12;
  localparam int CycleLimit  = 300000;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [ResOpW-1:0] op_res;
    logic [MacW-1:0]   eth_dst;
    logic [MacW-1:0]   target_mac;
    logic [IpW-1:0]    sender_ip;
    logic [IpW-1:0]    target_ip;
    logic              was_new;
    logic              full;
  } arp_result_t;

  typedef enum int {LEARN_KNOWN, LEARN_ADDED, LEARN_DROPPED} learn_t;

  class arp_scoreboard;
    logic [IpW-1:0]  local_ip = '0;
    logic [MacW-1:0] local_mac = '0;
    logic [IpW-1:0]  cached_ip[TableDepth];
    logic [MacW-1:0] cached_mac[TableDepth];
    int              cached_count = 0;
    arp_result_t     awaited_results[$];
    int              errors = 0;

    function void write_register(logic idx, logic [63:0] value);
      if (idx == REG_LOCAL_IP) local_ip = value[IpW-1:0];
      else local_mac = value[MacW-1:0];
    endfunction

    function bit lookup_mac(logic [IpW-1:0] ip, output logic [MacW-1:0] mac);
      mac = '0;
      for (int i = 0; i < cached_count; i++) begin
        if (cached_ip[i] == ip) begin
          mac = cached_mac[i];
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function learn_t learn(logic [IpW-1:0] ip, logic [MacW-1:0] mac);
      logic [MacW-1:0] known;
      if (lookup_mac(ip, known)) return LEARN_KNOWN;
      if (cached_count >= TableDepth) return LEARN_DROPPED;
      cached_ip[cached_count] = ip;
      cached_mac[cached_count] = mac;
      cached_count++;
      return LEARN_ADDED;
    endfunction

    // unicast to a cached host, broadcast otherwise
    function void queue_request(logic [IpW-1:0] ip);
      logic [MacW-1:0] mac;
      if (lookup_mac(ip, mac))
        awaited_results.push_back('{KIND_REQUEST, RES_OP_REQUEST, mac, mac, local_ip, ip,
                                    1'b0, 1'b0});
      else
        awaited_results.push_back('{KIND_REQUEST, RES_OP_REQUEST, BCAST_MAC, 48'd0,
                                    local_ip, ip, 1'b0, 1'b0});
    endfunction

    // returns 0 for an item the block ignores
    function bit resolve_item(item_t it);
      logic [MacW-1:0] mac;
      learn_t status;
      case (it.action)
        ACT_RX_ARP: begin
          if (it.target_ip != local_ip) return 1'b0;
          if (it.arp_op == ARP_OP_REQUEST)
            awaited_results.push_back('{KIND_REPLY, RES_OP_REPLY, it.sender_mac, it.sender_mac,
                                        local_ip, it.sender_ip, 1'b0, 1'b0});
          else if (it.arp_op == ARP_OP_REPLY)
            status = learn(it.sender_ip, it.sender_mac);
          else
            return 1'b0;
        end
        ACT_LOOKUP: begin
          if (lookup_mac(it.target_ip, mac))
            awaited_results.push_back('{KIND_FORWARD, RES_OP_NONE, mac, 48'd0, 32'd0,
                                        it.target_ip, 1'b0, 1'b0});
          else
            queue_request(it.target_ip);
        end
        ACT_PROBE: begin
          queue_request((local_ip & SUBNET_MASK) | {24'd0, it.host_number});
        end
        ACT_INSERT: begin
          status = learn(it.sender_ip, it.sender_mac);
          awaited_results.push_back('{KIND_STATUS, RES_OP_NONE, 48'd0, 48'd0, 32'd0, 32'd0,
                                      status != LEARN_KNOWN, status == LEARN_DROPPED});
        end
      endcase
      return 1'b1;
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      if (errors <= 30) $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    task check_result(arp_result_t got);
      arp_result_t want;
      if (awaited_results.size() == 0) begin
        report("result with nothing awaited", 64'(got.kind), 64'd0);
        return;
      end
      want = awaited_results.pop_front();
      if (got.kind !== want.kind) report("result_kind", 64'(got.kind), 64'(want.kind));
      if (got.op_res !== want.op_res) report("arp_op_res", 64'(got.op_res), 64'(want.op_res));
      if (got.eth_dst !== want.eth_dst)
        report("eth_dst_mac", 64'(got.eth_dst), 64'(want.eth_dst));
      if (got.target_mac !== want.target_mac)
        report("arp_target_mac", 64'(got.target_mac), 64'(want.target_mac));
      if (got.sender_ip !== want.sender_ip)
        report("arp_sender_ip", 64'(got.sender_ip), 64'(want.sender_ip));
      if (got.target_ip !== want.target_ip)
        report("arp_target_ip", 64'(got.target_ip), 64'(want.target_ip));
      if (got.was_new !== want.was_new) report("was_new", 64'(got.was_new), 64'(want.was_new));
      if (got.full !== want.full) report("table_full", 64'(got.full), 64'(want.full));
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [ActW-1:0]     s_axis_tuser = '0;
  logic                s_axis_tvalid = 1'b0;
  wire                 s_axis_tready;
  wire [OutDataW-1:0]  m_axis_tdata;
  wire [KindW-1:0]     m_axis_tuser;
  wire                 m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [3:0]          paddr = '0;
  logic [63:0]         pwdata = '0;
  wire [63:0]          prdata;
  wire                 pready;

  arp_scoreboard       board;
  int                  send_idle_pct = 0;
  int                  ready_stall_pct = 0;
  bit                  quiet = 1'b0;
  int unsigned         cycle_count = 0;
  logic [IpW-1:0]      ip_pool[PoolSize];

  arp_cache_and_responder #(
    .TABLE_DEPTH(TableDepth)
  ) u_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tdata,
    .s_axis_tuser,
    .s_axis_tvalid,
    .s_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= quiet || ($urandom_range(99) >= ready_stall_pct);
  end

  always @(posedge clk_i) begin
    arp_result_t got;
    got = {m_axis_tuser, m_axis_tdata[1:0], m_axis_tdata[49:2], m_axis_tdata[97:50],
           m_axis_tdata[129:98], m_axis_tdata[161:130], m_axis_tdata[162], m_axis_tdata[163]};
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_result(got);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [MacW-1:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  function automatic item_t make_item(logic [ActW-1:0] act, logic [OpW-1:0] op,
                                      logic [IpW-1:0] sip, logic [MacW-1:0] smac,
                                      logic [IpW-1:0] tip, logic [HostW-1:0] host);
    return '{act, op, sip, smac, tip, host};
  endfunction

  task automatic apb_access(logic idx, logic wr, logic [63:0] wdata, output logic [63:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 3'b000};
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_register(logic idx, logic [63:0] value);
    logic [63:0] readback;
    logic [63:0] mask;
    mask = (idx == REG_LOCAL_IP) ? 64'hFFFF_FFFF : 64'hFFFF_FFFF_FFFF;
    apb_access(idx, 1'b1, value, readback);
    board.write_register(idx, value);
    apb_access(idx, 1'b0, 64'd0, readback);
    if ((readback & mask) !== (value & mask))
      board.report("register readback", readback & mask, value & mask);
  endtask

  task automatic push_item(item_t it, output bit busy);
    while (!quiet && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.action;
    s_axis_tdata <= {it.host_number, it.target_ip, it.sender_mac, it.sender_ip, it.arp_op};
    do @(posedge clk_i); while (!s_axis_tready);
    busy = board.resolve_item(it);
  endtask

  // learning leaves no result behind, so wait out the pipeline after the last one
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (board.awaited_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    item_t           it;
    bit              busy;
    bit              paused;
    int              done;
    int              pick;
    int              mode;
    logic [IpW-1:0]  lip;
    logic [IpW-1:0]  phase_ip[PhaseCount];
    logic [MacW-1:0] phase_mac[PhaseCount];

    board = new();
    for (int i = 0; i < PoolSize; i++) begin
      if (i < 32) ip_pool[i] = {24'hC0A801, 8'($urandom)};
      else if (i < 48) ip_pool[i] = {24'h000000, 8'($urandom)};
      else if (i < 64) ip_pool[i] = {24'hFFFFFF, 8'($urandom)};
      else ip_pool[i] = $urandom;
    end
    ip_pool[40] = 32'h0000_0000;
    ip_pool[50] = 32'hFFFF_FFFF;
    phase_ip = '{32'hC0A8_0164, 32'h0000_0000, 32'hFFFF_FFFF, 32'hC0A8_01FE,
                 32'hC0A8_0101, $urandom, 32'h0000_0001, 32'hFFFF_FF00};
    phase_mac = '{48'h0200_00AB_CDEF, 48'h0, 48'hFFFF_FFFF_FFFF, rand48(),
                  rand48(), rand48(), 48'h0000_0000_0001, rand48()};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    lip = phase_ip[0];
    set_register(REG_LOCAL_IP, 64'(lip));
    set_register(REG_LOCAL_MAC, 64'(phase_mac[0]));

    // directed: opcode and address extremes, learning, probes, inserts
    push_item(make_item(ACT_RX_ARP, ARP_OP_REQUEST, 32'h0, 48'hFFFF_FFFF_FFFF, lip, 8'h0), busy);
    push_item(make_item(ACT_RX_ARP, ARP_OP_REQUEST, 32'hFFFF_FFFF, 48'h0, lip, 8'hFF), busy);
    push_item(make_item(ACT_RX_ARP, ARP_OP_REQUEST, 32'h0A00_0001, 48'h1, lip ^ 32'h1, 8'h0),
              busy);
    push_item(make_item(ACT_RX_ARP, 16'h0000, 32'h0A00_0002, 48'h2, lip, 8'h0), busy);
    push_item(make_item(ACT_RX_ARP, 16'hFFFF, 32'h0A00_0003, 48'h3, lip, 8'h0), busy);
    push_item(make_item(ACT_RX_ARP, 16'h0003, 32'h0A00_0004, 48'h4, lip, 8'h0), busy);
    push_item(make_item(ACT_LOOKUP, 16'h0, 32'h0, 48'h0, 32'hC0A8_0107, 8'h0), busy);
    push_item(make_item(ACT_RX_ARP, ARP_OP_REPLY, 32'hC0A8_0107, 48'h0A1B_2C3D_4E5F, lip, 8'h0),
              busy);
    push_item(make_item(ACT_LOOKUP, 16'h0, 32'h0, 48'h0, 32'hC0A8_0107, 8'h0), busy);
    push_item(make_item(ACT_RX_ARP, ARP_OP_REPLY, 32'hC0A8_0107, 48'hFFFF_FFFF_FFFF, lip, 8'h0),
              busy);
    push_item(make_item(ACT_LOOKUP, 16'h0, 32'h0, 48'h0, 32'hC0A8_0107, 8'h0), busy);
    push_item(make_item(ACT_PROBE, 16'h0, 32'h0, 48'h0, 32'h0, 8'h07), busy);
    push_item(make_item(ACT_PROBE, 16'h0, 32'h0, 48'h0, 32'h0, 8'h00), busy);
    push_item(make_item(ACT_PROBE, 16'hFFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                        8'hFF), busy);
    push_item(make_item(ACT_INSERT, 16'h0, 32'hFFFF_FFFF, 48'h0, 32'h0, 8'h0), busy);
    push_item(make_item(ACT_INSERT, 16'h0, 32'hFFFF_FFFF, 48'h5, 32'h0, 8'h0), busy);
    push_item(make_item(ACT_LOOKUP, 16'h0, 32'h0, 48'h0, 32'hFFFF_FFFF, 8'h0), busy);
    push_item(make_item(ACT_INSERT, 16'hFFFF, 32'h0, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8'hFF),
              busy);
    push_item(make_item(ACT_LOOKUP, 16'h0, 32'h0, 48'h0, 32'h0, 8'h0), busy);
    push_item(make_item(ACT_RX_ARP, ARP_OP_REPLY, 32'h0B0B_0B0B, 48'h6, ~lip, 8'h0), busy);
    push_item(make_item(ACT_LOOKUP, 16'h0, 32'h0, 48'h0, 32'h0B0B_0B0B, 8'h0), busy);
    drain_results();

    for (int p = 0; p < PhaseCount; p++) begin
      if (p > 0) begin
        set_register(REG_LOCAL_IP, 64'(phase_ip[p]));
        set_register(REG_LOCAL_MAC, 64'(phase_mac[p]));
      end
      mode = p % 4;
      send_idle_pct <= (mode == 1) ? 68 : (mode == 3) ? 38 : 0;
      ready_stall_pct <= (mode == 2) ? 68 : (mode == 3) ? 38 : 0;
      done = 0;
      paused = 1'b0;
      for (int n = 0; done < PhaseItems; n++) begin
        if (n % 40 == 0) quiet <= (mode != 0) && ($urandom_range(3) == 0);
        if (!paused && done >= PhaseItems / 2) begin
          drain_results();
          paused = 1'b1;
        end
        it.action = ActW'($urandom_range(3));
        it.arp_op = OpW'($urandom);
        it.sender_ip = $urandom;
        it.sender_mac = rand48();
        it.target_ip = $urandom;
        it.host_number = HostW'($urandom);
        pick = $urandom_range(99);
        case (it.action)
          ACT_RX_ARP: begin
            if (pick < 45) it.arp_op = ARP_OP_REQUEST;
            else if (pick < 85) it.arp_op = ARP_OP_REPLY;
            if ($urandom_range(99) < 85) it.target_ip = board.local_ip;
            if ($urandom_range(99) < 80) it.sender_ip = ip_pool[$urandom_range(PoolSize - 1)];
          end
          ACT_LOOKUP: begin
            if (pick < 75) it.target_ip = ip_pool[$urandom_range(PoolSize - 1)];
          end
          ACT_PROBE: begin
            if (pick < 50) it.host_number = ip_pool[$urandom_range(PoolSize - 1)][HostW-1:0];
          end
          ACT_INSERT: begin
            if (pick < 70) it.sender_ip = ip_pool[$urandom_range(PoolSize - 1)];
          end
        endcase
        push_item(it, busy);
        if (busy) done++;
      end
      quiet <= 1'b0;
      drain_results();
    end

    if (board.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
